[rtl/smct_pkg.sv]
// smct_pkg: shared types and codes for the sparse matrix coordinate table
// used by smct_ctrl, smct_datapath and the top level; no dependencies
package smct_pkg;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // request kind carried on tuser
   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_LOOKUP = 1'b1;

   // register index decoded from the csr address
   localparam logic REG_ROW_COUNT    = 1'b0;
   localparam logic REG_COLUMN_COUNT = 1'b1;

   localparam int DIM_W   = 16;
   localparam int VALUE_W = 32;
   localparam int ENTRY_W = 2 * DIM_W + VALUE_W;

   // controller to datapath
   typedef struct packed {
      logic       load;       // latch the request beat
      logic       ram_wr;     // append entry, bump count
      logic       idx_clear;  // restart the scan
      logic       scan;       // issue next entry read
      logic       res_load;   // capture the result
      status_type res_status;
      logic       res_found;
      logic       out_load;   // move result into the output register
   } smct_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_lookup;
      logic full;
      logic in_range;
      logic hit;
      logic scan_end;
      logic out_free;
   } smct_stat_type;

endpackage

[rtl/smct_ram.sv]
// smct_ram: generic single-write, single-read ram with registered read data
// no package dependencies
module smct_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/smct_datapath.sv]
// smct_datapath: request latch, entry store, scan compare, result and output registers
// depends on smct_pkg and smct_ram
module smct_datapath #(
   parameter int CAPACITY = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  smct_pkg::smct_cmd_type            cmd,
   output smct_pkg::smct_stat_type           stat,
   input  logic                              req_tuser,
   input  logic [63:0]                       req_tdata,
   input  logic [smct_pkg::DIM_W-1:0]        row_count,
   input  logic [smct_pkg::DIM_W-1:0]        column_count,
   input  logic                              rsp_tready,
   output logic                              rsp_tvalid,
   output logic [31:0]                       rsp_tdata,
   output logic [2:0]                        rsp_tuser
);
   import smct_pkg::*;

   localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W  = $clog2(CAPACITY + 1);

   logic                mode_ff;
   logic [DIM_W-1:0]    key_row_ff;
   logic [DIM_W-1:0]    key_col_ff;
   logic [VALUE_W-1:0]  key_value_ff;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic                rd_vld_ff, rd_vld_in;
   logic                issue;
   logic [ENTRY_W-1:0]  rd_data;
   status_type          res_status_ff;
   logic                res_found_ff;
   logic [VALUE_W-1:0]  res_value_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff;
   logic                rsp_found_ff;
   logic [VALUE_W-1:0]  rsp_value_ff;

   assign issue     = cmd.scan && (idx_ff != count_ff);
   assign rd_vld_in = issue;

   always_comb begin
      priority if (cmd.idx_clear) begin
         idx_in = '0;
      end else if (issue) begin
         idx_in = idx_ff + 1'b1;
      end else begin
         idx_in = idx_ff;
      end
   end

   assign count_in = cmd.ram_wr ? count_ff + 1'b1 : count_ff;

   always_comb begin
      priority if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   smct_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CAPACITY)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (cmd.ram_wr),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data ({key_value_ff, key_col_ff, key_row_ff}),
      .rd_en   (issue),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         idx_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff      <= req_tuser;
         key_row_ff   <= req_tdata[15:0];
         key_col_ff   <= req_tdata[31:16];
         key_value_ff <= req_tdata[63:32];
      end
      if (cmd.res_load) begin
         res_status_ff <= cmd.res_status;
         res_found_ff  <= cmd.res_found;
         res_value_ff  <= cmd.res_found ? rd_data[ENTRY_W-1:2*DIM_W] : '0;
      end
      if (cmd.out_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_found_ff  <= res_found_ff;
         rsp_value_ff  <= res_value_ff;
      end
   end

   assign stat.is_lookup = (mode_ff == MODE_LOOKUP);
   assign stat.full      = (count_ff >= CNT_W'(CAPACITY));
   assign stat.in_range  = (key_row_ff != '0) && (key_row_ff <= row_count) &&
                           (key_col_ff != '0) && (key_col_ff <= column_count);
   assign stat.hit       = rd_vld_ff && (rd_data[DIM_W-1:0] == key_row_ff) &&
                           (rd_data[2*DIM_W-1:DIM_W] == key_col_ff);
   assign stat.scan_end  = !rd_vld_ff && (idx_ff == count_ff);
   assign stat.out_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = {rsp_found_ff, rsp_status_ff};

   a_wr_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.ram_wr |-> !stat.full)
      else $error("entry write while table full");

   a_wr_counts: assert property (@(posedge clock) disable iff (reset)
      cmd.ram_wr |=> count_ff == $past(count_ff) + 1'b1)
      else $error("entry count did not advance on write");

   a_out_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid_ff && (rsp_status_ff == $past(res_status_ff)))
      else $error("output register not loaded");

endmodule

[rtl/smct_ctrl.sv]
// smct_ctrl: state machine sequencing insert, range check, scan and result hand-off
// depends on smct_pkg
module smct_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  smct_pkg::smct_stat_type stat,
   output smct_pkg::smct_cmd_type  cmd
);
   import smct_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EXEC = 4'b0010,
      ST_SCAN = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.res_status = STATUS_OK;
      req_tready     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            priority if (!stat.is_lookup && stat.full) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = STATUS_FULL;
               state_in       = ST_DONE;
            end else if (!stat.is_lookup) begin
               cmd.ram_wr   = 1'b1;
               cmd.res_load = 1'b1;
               state_in     = ST_DONE;
            end else if (!stat.in_range) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = STATUS_RANGE;
               state_in       = ST_DONE;
            end else begin
               cmd.idx_clear = 1'b1;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            priority if (stat.hit) begin
               cmd.res_load  = 1'b1;
               cmd.res_found = 1'b1;
               state_in      = ST_DONE;
            end else if (stat.scan_end) begin
               cmd.res_load = 1'b1;
               state_in     = ST_DONE;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_DONE: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> state_ff == ST_EXEC)
      else $error("accepted beat not executed");

   a_hit_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && stat.hit) |=> state_ff == ST_DONE)
      else $error("scan hit did not finish the lookup");

   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> stat.out_free)
      else $error("result loaded over a pending beat");

endmodule

[rtl/sparse_matrix_coordinate_table.sv]
// sparse_matrix_coordinate_table: top level, csr registers and stream ports
// depends on smct_pkg, smct_ctrl, smct_datapath (and smct_ram through it)
//
// Sparse matrix held as a coordinate list of up to CAPACITY (row, column, value)
// entries in insertion order, in one ram. A request beat with tuser 0 appends an
// entry (no duplicate or bounds check; status full once CAPACITY entries are
// stored). A beat with tuser 1 looks up row/col: indices outside
// 1..row_count / 1..column_count give status range, otherwise the entries are
// scanned oldest first and the first match returns its value with found set.
// One request is worked on at a time. An insert or an out-of-range lookup goes
// straight from accept to the result; an in-range lookup scans the entry ram,
// one read per cycle, comparing each entry as its registered read data returns,
// and ends on the first match or after the last stored entry is compared.
// A finished result waits in the output register while the next beat is taken;
// the result after it stalls in the block until the receiver takes the first.
// row_count sits at csr address 0 and column_count at 4, both reset to 1;
// write them only while the block is idle.
module sparse_matrix_coordinate_table #(
   parameter int CAPACITY = 256
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // row [15:0], col [31:16], value (signed) [63:32]
   input  logic        req_tuser,   // mode [0]: 0 insert, 1 lookup
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // read_value (signed) [31:0]
   output logic [2:0]  rsp_tuser,   // status [1:0], found [2]
   // csr port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import smct_pkg::*;

   logic [DIM_W-1:0] row_count_ff, row_count_in;
   logic [DIM_W-1:0] column_count_ff, column_count_in;
   logic             csr_wr;
   logic             reg_sel;
   smct_cmd_type     cmd;
   smct_stat_type    stat;

   // always ready
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   // word index; low byte-offset bits are don't care
   assign reg_sel    = csr_paddr[2];

   always_comb begin
      row_count_in    = row_count_ff;
      column_count_in = column_count_ff;
      if (csr_wr) begin
         unique case (reg_sel)
            REG_ROW_COUNT:    row_count_in    = csr_pwdata[DIM_W-1:0];
            REG_COLUMN_COUNT: column_count_in = csr_pwdata[DIM_W-1:0];
            default: begin
               row_count_in = row_count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff    <= DIM_W'(1);
         column_count_ff <= DIM_W'(1);
      end else begin
         row_count_ff    <= row_count_in;
         column_count_ff <= column_count_in;
      end
   end

   // read back, zero extended
   assign csr_prdata = (reg_sel == REG_COLUMN_COUNT) ? {16'd0, column_count_ff}
                                                     : {16'd0, row_count_ff};

   // sequencing
   smct_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // entry store, compare and output register
   smct_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_tuser    (req_tuser),
      .req_tdata    (req_tdata),
      .row_count    (row_count_ff),
      .column_count (column_count_ff),
      .rsp_tready   (rsp_tready),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser)
   );

endmodule
